[sv/cht_pkg.sv]
package cht_pkg;

  // Table geometry. BUCKETS must stay a power of two: the bucket index is
  // the low bits of the key.
  localparam int BUCKETS    = 16;
  localparam int POOL_NODES = 64;

  localparam int KEY_W  = 31;
  localparam int VAL_W  = 32;
  localparam int BKT_W  = $clog2(BUCKETS);
  localparam int NODE_W = $clog2(POOL_NODES);
  localparam int CNT_W  = $clog2(POOL_NODES + 1);
  localparam int STAT_W = 2;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_HIT      = 2'd1,
    ST_MISS     = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_SEARCH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_LINK,
    S_WALK
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;      // capture the input transaction
    logic    node_wr;   // write the new node (key, value, no link)
    logic    link_upd;  // hook the new node onto its bucket, bump the count
    logic    rd_head;   // read the node at the bucket head
    logic    rd_link;   // read the node the current one links to
    logic    emit;      // drive a result next cycle
    status_t status;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_search;
    logic pool_full;
    logic bkt_used;
    logic key_match;
    logic has_link;
  } dp_stat_t;

endpackage

[sv/cht_ctrl.sv]
module cht_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  cht_pkg::dp_stat_t  stat,
  output cht_pkg::dp_cmd_t   cmd,
  output logic               busy
);
  import cht_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.status = ST_INSERTED;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!stat.is_search) begin
          if (stat.pool_full) begin
            cmd.emit   = 1'b1;
            cmd.status = ST_FULL;
            state_nxt  = S_IDLE;
          end else begin
            cmd.node_wr = 1'b1;
            state_nxt   = S_INS_LINK;
          end
        end else if (!stat.bkt_used) begin
          cmd.emit   = 1'b1;
          cmd.status = ST_MISS;
          state_nxt  = S_IDLE;
        end else begin
          cmd.rd_head = 1'b1;
          state_nxt   = S_WALK;
        end
      end
      S_INS_LINK: begin
        cmd.link_upd = 1'b1;
        cmd.emit     = 1'b1;
        cmd.status   = ST_INSERTED;
        state_nxt    = S_IDLE;
      end
      S_WALK: begin
        if (stat.key_match) begin
          cmd.emit   = 1'b1;
          cmd.status = ST_HIT;
          state_nxt  = S_IDLE;
        end else if (stat.has_link) begin
          cmd.rd_link = 1'b1;
        end else begin
          cmd.emit   = 1'b1;
          cmd.status = ST_MISS;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

[sv/cht_dp.sv]
module cht_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cht_pkg::dp_cmd_t                  cmd,
  output cht_pkg::dp_stat_t                 stat,
  input  logic                              in_cmd,
  input  logic        [cht_pkg::KEY_W-1:0]  in_key,
  input  logic signed [cht_pkg::VAL_W-1:0]  in_value,
  output logic                              out_valid,
  output logic        [cht_pkg::STAT_W-1:0] out_status,
  output logic signed [cht_pkg::VAL_W-1:0]  out_value_out
);
  import cht_pkg::*;

  localparam int KV_W = KEY_W + VAL_W;
  localparam int LK_W = NODE_W + 1;

  // Captured transaction
  logic              op_r;
  logic [KEY_W-1:0]  key_r;
  logic [VAL_W-1:0]  value_r;

  // Bucket directory
  logic [BUCKETS-1:0] bkt_used_r;
  logic [NODE_W-1:0]  head_r [BUCKETS];
  logic [NODE_W-1:0]  tail_r [BUCKETS];
  logic [CNT_W-1:0]   used_cnt_r;

  // Node pool: key/value and link kept in separate memories
  logic [KV_W-1:0] kv_mem [POOL_NODES];
  logic [LK_W-1:0] lk_mem [POOL_NODES];
  logic [KV_W-1:0] kv_rd_r;
  logic [LK_W-1:0] lk_rd_r;

  logic                out_valid_r;
  logic [STAT_W-1:0]   out_status_r;
  logic [VAL_W-1:0]    out_value_r;

  logic [BKT_W-1:0]  bkt;
  logic [NODE_W-1:0] new_node;
  logic [NODE_W-1:0] rd_addr;
  logic              rd_en;
  logic              lk_wr_en;
  logic [NODE_W-1:0] lk_wr_addr;
  logic [LK_W-1:0]   lk_wr_data;

  assign bkt      = key_r[BKT_W-1:0];
  assign new_node = used_cnt_r[NODE_W-1:0];
  assign rd_en    = cmd.rd_head | cmd.rd_link;
  assign rd_addr  = cmd.rd_link ? lk_rd_r[NODE_W-1:0] : head_r[bkt];

  // The new node gets an empty link; the old tail links to the new node.
  assign lk_wr_en   = cmd.node_wr | (cmd.link_upd & bkt_used_r[bkt]);
  assign lk_wr_addr = cmd.node_wr ? new_node : tail_r[bkt];
  assign lk_wr_data = cmd.node_wr ? '0 : {1'b1, new_node};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_cmd;
      key_r   <= in_key;
      value_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bkt_used_r <= '0;
      used_cnt_r <= '0;
    end else if (cmd.link_upd) begin
      bkt_used_r[bkt] <= 1'b1;
      used_cnt_r      <= used_cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.link_upd) begin
      tail_r[bkt] <= new_node;
      if (!bkt_used_r[bkt]) begin
        head_r[bkt] <= new_node;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.node_wr) begin
      kv_mem[new_node] <= {key_r, value_r};
    end
    if (rd_en) begin
      kv_rd_r <= kv_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (lk_wr_en) begin
      lk_mem[lk_wr_addr] <= lk_wr_data;
    end
    if (rd_en) begin
      lk_rd_r <= lk_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.status;
      out_value_r  <= (cmd.status == ST_HIT) ? kv_rd_r[VAL_W-1:0] : '0;
    end
  end

  assign stat.is_search = (op_r == CMD_SEARCH);
  assign stat.pool_full = (used_cnt_r == CNT_W'(POOL_NODES));
  assign stat.bkt_used  = bkt_used_r[bkt];
  assign stat.key_match = (kv_rd_r[KV_W-1:VAL_W] == key_r);
  assign stat.has_link  = lk_rd_r[NODE_W];

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_out = out_value_r;

endmodule

[sv/chained_hash_table.sv]
// Key-value store with separate chaining over a pool of 64 nodes and 16
// buckets (bucket = low 4 bits of the key). A transaction is taken on a
// rising edge with start high and busy low; busy then stays high until the
// result is produced. Each transaction gives exactly one result, shown for
// one cycle with out_valid high; there is no backpressure, so capture it in
// that cycle. An insert passes through dispatch and link-up; a search on an
// empty bucket answers a miss from dispatch, and a search walks its chain
// from the head, since the walk reads one node per cycle, key/value and link
// at one address of the two node memories. The next transaction may start in the cycle its
// predecessor's result is shown. Duplicate keys are kept and a search
// returns the oldest one; nodes are never freed, and once all 64 are used
// every insert answers pool full with no change of state.
module chained_hash_table (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_cmd,
  input  logic        [cht_pkg::KEY_W-1:0]  in_key,
  input  logic signed [cht_pkg::VAL_W-1:0]  in_value,
  output logic                              out_valid,
  output logic        [cht_pkg::STAT_W-1:0] out_status,
  output logic signed [cht_pkg::VAL_W-1:0]  out_value_out
);
  import cht_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence each transaction: dispatch, then insert link-up or chain walk where needed
  cht_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Hold the bucket directory, node memories and result register
  cht_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_cmd        (in_cmd),
    .in_key        (in_key),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_value_out (out_value_out)
  );

endmodule

[sv/cht_chk.sv]
module cht_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic        [cht_pkg::STAT_W-1:0] out_status,
  input logic signed [cht_pkg::VAL_W-1:0]  out_value_out
);
  import cht_pkg::*;

  // An accepted transaction keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a transaction");

  // A result only follows a busy cycle
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a transaction in progress");

  // Leaving busy always delivers a result
  a_done_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("transaction finished without a result");

  // Results never arrive in consecutive cycles
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // Only a search hit carries a nonzero value
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_HIT)) |-> (out_value_out == '0))
    else $error("nonzero value on a result that is not a hit");

endmodule

bind chained_hash_table cht_chk u_cht_chk (.*);
